FILE: rtl/core/tcw_pkg.sv
// Shared types and constants for the text console character writer.
// Cell layout, command codes and controller states. No dependencies.
`default_nettype none

package tcw_pkg;

  localparam int POS_W  = 11;
  localparam int BYTE_W = 8;

  localparam logic [BYTE_W-1:0] NEWLINE_CODE     = 8'd10;
  localparam logic [BYTE_W-1:0] SPACE_CODE       = 8'd32;
  localparam logic [BYTE_W-1:0] RESET_BLANK_ATTR = 8'd15;

  typedef struct packed {
    logic [BYTE_W-1:0] attr;
    logic [BYTE_W-1:0] chr;
  } cell_t;

  typedef enum logic [1:0] {
    CMD_PUT_CURSOR = 2'd0,
    CMD_PUT_POS    = 2'd1,
    CMD_READ       = 2'd2,
    CMD_SET_CURSOR = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_DIV,
    ST_SCROLL,
    ST_BLANK,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/core/tcw_rem.sv
// Remainder unit: dividend modulo a constant by reciprocal multiplication.
// Quotient at start, then remainder with done. No package dependencies.
`default_nettype none

module tcw_rem #(
  parameter int WIDTH   = 11,
  parameter int DIVISOR = 80
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [WIDTH-1:0]             dividend_i,
  output logic                         done_o,
  output logic [$clog2(DIVISOR)-1:0]   rem_o
);

  localparam int RW    = $clog2(DIVISOR);
  localparam int SHIFT = WIDTH + RW;
  localparam int PW    = SHIFT + WIDTH;
  // floor(x * MAGIC / 2^SHIFT) equals floor(x / DIVISOR) for every WIDTH-bit x
  localparam logic [PW-1:0] MAGIC = PW'((64'd1 << SHIFT) / DIVISOR + 1);

  logic [PW-1:0]    prod;
  logic [WIDTH-1:0] quot_q, dvd_q, row_base;
  logic [RW-1:0]    rem_q;
  logic             stage_q, done_q;

  assign prod     = PW'(dividend_i) * MAGIC;
  assign row_base = quot_q * WIDTH'(DIVISOR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      stage_q <= start_i;
      done_q  <= stage_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= prod[SHIFT +: WIDTH];
      dvd_q  <= dividend_i;
    end
    if (stage_q) begin
      rem_q <= RW'(dvd_q - row_base);
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

FILE: rtl/core/text_console_char_writer.sv
// Text console character writer: cell memory, cursor and scroll sequencer.
// Depends on tcw_pkg and tcw_rem.
//
//   port group       dir   handshake            payload
//   input item       in    in_valid/in_ready    cmd, char_code, attribute, position
//   result item      out   out_valid/out_ready  cursor_now, read_char, read_attribute, scrolled
//   blank attribute  in    blank_attribute_we   blank_attribute
//
// One transaction at a time. Write, set cursor or out-of-range command: ST_EXEC, ST_DONE;
// read: ST_EXEC, ST_READ, ST_DONE; newline: ST_EXEC, ST_DIV while the remainder unit works.
// A scroll copies the store up a row through the single memory port pair, one cell per
// cycle, and blanks the last row. After reset a clearing pass blanks every cell of the memory
// before in_ready_o rises. A held result stalls completion, not acceptance.
`default_nettype none

module text_console_char_writer #(
  parameter int ROWS    = 25,
  parameter int COLUMNS = 80
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 cmd_i,
  input  logic [7:0]                 char_code_i,
  input  logic [7:0]                 attribute_i,
  input  logic [tcw_pkg::POS_W-1:0]  position_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [tcw_pkg::POS_W-1:0]  cursor_now_o,
  output logic [7:0]                 read_char_o,
  output logic [7:0]                 read_attribute_o,
  output logic                       scrolled_o,
  input  logic                       blank_attribute_we_i,
  input  logic [7:0]                 blank_attribute_i
);

  import tcw_pkg::*;

  localparam int N  = ROWS * COLUMNS;
  localparam int AW = $clog2(N);
  localparam int CW = (AW > POS_W) ? AW : POS_W;
  localparam int TW = AW + 1;
  localparam int RW = $clog2(COLUMNS);

  localparam logic [AW-1:0] COPY_END  = AW'(N - COLUMNS);
  localparam logic [AW-1:0] LAST_CELL = AW'(N - 1);

  state_e          state_q, state_d;
  logic [AW-1:0]   cnt_q, cnt_d;
  logic            pend_q, pend_d;
  logic [AW-1:0]   wa_q, wa_d;
  logic [CW-1:0]   cursor_q, cursor_d;
  logic [7:0]      blank_attr_q;

  cmd_e            cmd_q;
  logic [7:0]      char_q, attr_q;
  logic [CW-1:0]   pos_q;
  cell_t           res_rd_q, res_rd_d;
  logic            res_scr_q, res_scr_d;

  logic            out_valid_q, out_valid_d;
  logic [POS_W-1:0] out_cursor_q;
  cell_t           out_rd_q;
  logic            out_scr_q;
  logic            out_load;

  cell_t           mem [N];
  logic            wr_en, rd_en;
  logic [AW-1:0]   wr_addr, rd_addr;
  cell_t           wr_data, rdata_q;

  logic            div_start, div_done;
  logic [RW-1:0]   div_rem;
  logic [AW-1:0]   src;
  logic [TW-1:0]   target, next_cell;
  logic            pos_ok, accept;

  assign accept    = in_valid_i && in_ready_o;
  assign pos_ok    = pos_q < CW'(N);
  assign src       = (cmd_q == CMD_PUT_CURSOR) ? cursor_q[AW-1:0] : pos_q[AW-1:0];
  assign target    = TW'(src) - TW'(div_rem) + TW'(COLUMNS);
  assign next_cell = TW'(cursor_q[AW-1:0]) + TW'(1);

  tcw_rem #(
    .WIDTH  (AW),
    .DIVISOR(COLUMNS)
  ) u_rem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(src),
    .done_o    (div_done),
    .rem_o     (div_rem)
  );

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    pend_d    = 1'b0;
    wa_d      = wa_q;
    cursor_d  = cursor_q;
    res_rd_d  = res_rd_q;
    res_scr_d = res_scr_q;
    wr_en     = 1'b0;
    wr_addr   = cnt_q;
    wr_data   = '{attr: RESET_BLANK_ATTR, chr: SPACE_CODE};
    rd_en     = 1'b0;
    rd_addr   = pos_q[AW-1:0];
    div_start = 1'b0;
    out_load  = 1'b0;
    in_ready_o = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        wr_en = 1'b1;
        cnt_d = cnt_q + AW'(1);
        if (cnt_q == LAST_CELL) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_rd_d  = '0;
        res_scr_d = 1'b0;
        state_d   = ST_DONE;
        unique case (cmd_q)
          CMD_PUT_CURSOR: begin
            if (char_q == NEWLINE_CODE) begin
              div_start = 1'b1;
              state_d   = ST_DIV;
            end else begin
              wr_en   = 1'b1;
              wr_addr = cursor_q[AW-1:0];
              wr_data = '{attr: attr_q, chr: char_q};
              if (next_cell >= TW'(N)) begin
                res_scr_d = 1'b1;
                cnt_d     = '0;
                state_d   = ST_SCROLL;
              end else begin
                cursor_d = CW'(next_cell);
              end
            end
          end
          CMD_PUT_POS: begin
            if (pos_ok) begin
              if (char_q == NEWLINE_CODE) begin
                div_start = 1'b1;
                state_d   = ST_DIV;
              end else begin
                wr_en   = 1'b1;
                wr_addr = pos_q[AW-1:0];
                wr_data = '{attr: attr_q, chr: char_q};
              end
            end
          end
          CMD_READ: begin
            if (pos_ok) begin
              rd_en   = 1'b1;
              state_d = ST_READ;
            end
          end
          CMD_SET_CURSOR: begin
            if (pos_ok) begin
              cursor_d = pos_q;
            end
          end
          default: ;
        endcase
      end
      ST_READ: begin
        res_rd_d = rdata_q;
        state_d  = ST_DONE;
      end
      ST_DIV: begin
        if (div_done) begin
          if (target >= TW'(N)) begin
            res_scr_d = 1'b1;
            cnt_d     = '0;
            state_d   = ST_SCROLL;
          end else begin
            cursor_d = CW'(target);
            state_d  = ST_DONE;
          end
        end
      end
      ST_SCROLL: begin
        // read cell k+COLUMNS, write it to k in the next cycle
        wr_en   = pend_q;
        wr_addr = wa_q;
        wr_data = rdata_q;
        if (cnt_q != COPY_END) begin
          rd_en   = 1'b1;
          rd_addr = AW'(TW'(cnt_q) + TW'(COLUMNS));
          pend_d  = 1'b1;
          wa_d    = cnt_q;
          cnt_d   = cnt_q + AW'(1);
        end else begin
          state_d = ST_BLANK;
        end
      end
      ST_BLANK: begin
        wr_en   = 1'b1;
        wr_data = '{attr: blank_attr_q, chr: SPACE_CODE};
        cnt_d   = cnt_q + AW'(1);
        if (cnt_q == LAST_CELL) begin
          cursor_d = CW'(COPY_END);
          state_d  = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      cnt_q        <= '0;
      pend_q       <= 1'b0;
      cursor_q     <= '0;
      blank_attr_q <= RESET_BLANK_ATTR;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      cursor_q    <= cursor_d;
      out_valid_q <= out_valid_d;
      if (blank_attribute_we_i) begin
        blank_attr_q <= blank_attribute_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wa_q      <= wa_d;
    res_rd_q  <= res_rd_d;
    res_scr_q <= res_scr_d;
    if (accept) begin
      cmd_q  <= cmd_e'(cmd_i);
      char_q <= char_code_i;
      attr_q <= attribute_i;
      pos_q  <= CW'(position_i);
    end
    if (out_load) begin
      out_cursor_q <= cursor_q[POS_W-1:0];
      out_rd_q     <= res_rd_q;
      out_scr_q    <= res_scr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign cursor_now_o     = out_cursor_q;
  assign read_char_o      = out_rd_q.chr;
  assign read_attribute_o = out_rd_q.attr;
  assign scrolled_o       = out_scr_q;

  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q < CW'(N))
    else $error("cursor beyond last cell");

  a_scroll_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BLANK && cnt_q == LAST_CELL) |=> cursor_q == CW'(COPY_END))
    else $error("scroll did not park cursor at last row");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_DONE) |-> !wr_en)
    else $error("memory write outside of a transaction");

  a_rem_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("remainder finished outside newline handling");

endmodule

`default_nettype wire

FILE: dv/console_checker.sv
// Checker for the text console character writer: watches both channels,
// predicts each result from its own console model and compares. Depends on tcw_pkg.
`default_nettype none

module console_checker #(
  parameter int ROWS    = 25,
  parameter int COLUMNS = 80
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic [1:0]                cmd_i,
  input  logic [7:0]                char_code_i,
  input  logic [7:0]                attribute_i,
  input  logic [tcw_pkg::POS_W-1:0] position_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic [tcw_pkg::POS_W-1:0] cursor_now_i,
  input  logic [7:0]                read_char_i,
  input  logic [7:0]                read_attribute_i,
  input  logic                      scrolled_i,
  input  logic                      blank_attribute_we_i,
  input  logic [7:0]                blank_attribute_i,
  output int                        fails_o,
  output int                        pending_o
);
  import tcw_pkg::*;

  localparam int CELL_TOTAL = ROWS * COLUMNS;

  typedef struct packed {
    logic [POS_W-1:0] cursor_now;
    logic [7:0]       read_char;
    logic [7:0]       read_attr;
    logic             scrolled;
  } console_result_t;

  cell_t             screen [CELL_TOTAL];
  int                cursor_pos;
  logic [7:0]        blank_attr;
  console_result_t   result_q [$];
  console_result_t   predicted;
  console_result_t   oldest;
  int                mismatches;

  function automatic logic move_cursor(int target);
    if (target >= CELL_TOTAL) begin
      for (int k = 0; k + COLUMNS < CELL_TOTAL; k++) screen[k] = screen[k + COLUMNS];
      for (int k = CELL_TOTAL - COLUMNS; k < CELL_TOTAL; k++) begin
        screen[k] = '{attr: blank_attr, chr: SPACE_CODE};
      end
      cursor_pos = CELL_TOTAL - COLUMNS;
      return 1'b1;
    end
    cursor_pos = target;
    return 1'b0;
  endfunction

  task automatic predict_console(input cmd_e c, input logic [7:0] ch, input logic [7:0] at,
                                 input logic [POS_W-1:0] p, output console_result_t r);
    int  here;
    int  pos;
    r    = '0;
    here = cursor_pos;
    pos  = int'(p);
    case (c)
      CMD_PUT_CURSOR: begin
        if (ch == NEWLINE_CODE) begin
          r.scrolled = move_cursor((here / COLUMNS + 1) * COLUMNS);
        end else begin
          screen[here] = '{attr: at, chr: ch};
          r.scrolled = move_cursor(here + 1);
        end
      end
      CMD_PUT_POS: begin
        if (pos < CELL_TOTAL) begin
          if (ch == NEWLINE_CODE) begin
            r.scrolled = move_cursor((pos / COLUMNS + 1) * COLUMNS);
          end else begin
            screen[pos] = '{attr: at, chr: ch};
          end
        end
      end
      CMD_READ: begin
        if (pos < CELL_TOTAL) begin
          r.read_char = screen[pos].chr;
          r.read_attr = screen[pos].attr;
        end
      end
      default: begin
        if (pos < CELL_TOTAL) cursor_pos = pos;
      end
    endcase
    r.cursor_now = POS_W'(cursor_pos);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blank_attr = RESET_BLANK_ATTR;
      for (int k = 0; k < CELL_TOTAL; k++) screen[k] = '{attr: RESET_BLANK_ATTR, chr: SPACE_CODE};
      cursor_pos = 0;
      result_q.delete();
      mismatches = 0;
      fails_o   <= 0;
      pending_o <= 0;
    end else begin
      if (blank_attribute_we_i) blank_attr = blank_attribute_i;
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          $error("unexpected result: cursor_now %0d scrolled %0d", cursor_now_i, scrolled_i);
          mismatches++;
        end else begin
          oldest = result_q.pop_front();
          if (cursor_now_i !== oldest.cursor_now) begin
            $error("cursor_now: expected %0d, actual %0d", oldest.cursor_now, cursor_now_i);
            mismatches++;
          end
          if (read_char_i !== oldest.read_char) begin
            $error("read_char: expected %0d, actual %0d", oldest.read_char, read_char_i);
            mismatches++;
          end
          if (read_attribute_i !== oldest.read_attr) begin
            $error("read_attribute: expected %0d, actual %0d", oldest.read_attr,
                   read_attribute_i);
            mismatches++;
          end
          if (scrolled_i !== oldest.scrolled) begin
            $error("scrolled: expected %0d, actual %0d", oldest.scrolled, scrolled_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_console(cmd_e'(cmd_i), char_code_i, attribute_i, position_i, predicted);
        result_q.push_back(predicted);
      end
      fails_o   <= mismatches;
      pending_o <= result_q.size();
    end
  end

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// Top of the console writer testbench: clock, reset, stimulus phases and verdict.
// Depends on tcw_pkg, text_console_char_writer and console_checker.
`default_nettype none

module testbench;
  import tcw_pkg::*;

  localparam int ROWS           = 25;
  localparam int COLUMNS        = 80;
  localparam int CELL_TOTAL     = ROWS * COLUMNS;
  localparam int WATCHDOG_LIMIT = 50000;
  localparam int DRAIN_CYCLES   = 20;

  logic             clk_i                = 1'b0;
  logic             rst_ni               = 1'b0;
  logic             in_valid_i           = 1'b0;
  logic             in_ready_o;
  logic [1:0]       cmd_i                = '0;
  logic [7:0]       char_code_i          = '0;
  logic [7:0]       attribute_i          = '0;
  logic [POS_W-1:0] position_i           = '0;
  logic             out_valid_o;
  logic             out_ready_i          = 1'b0;
  logic [POS_W-1:0] cursor_now_o;
  logic [7:0]       read_char_o;
  logic [7:0]       read_attribute_o;
  logic             scrolled_o;
  logic             blank_attribute_we_i = 1'b0;
  logic [7:0]       blank_attribute_i    = '0;

  int               fails;
  int               pending;
  int               idle_pct  = 0;
  int               stall_pct = 0;
  int               quiet_cycles = 0;
  logic [POS_W-1:0] last_put_pos = '0;

  int               idle_tbl  [4] = '{0, 50, 0, 19};
  int               stall_tbl [4] = '{0, 0, 50, 19};

  text_console_char_writer #(.ROWS(ROWS), .COLUMNS(COLUMNS)) uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .cmd_i, .char_code_i, .attribute_i,
    .position_i, .out_valid_o, .out_ready_i, .cursor_now_o, .read_char_o,
    .read_attribute_o, .scrolled_o, .blank_attribute_we_i, .blank_attribute_i
  );

  console_checker #(.ROWS(ROWS), .COLUMNS(COLUMNS)) u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .cmd_i, .char_code_i,
    .attribute_i, .position_i, .out_valid_i(out_valid_o), .out_ready_i,
    .cursor_now_i(cursor_now_o), .read_char_i(read_char_o),
    .read_attribute_i(read_attribute_o), .scrolled_i(scrolled_o), .blank_attribute_we_i,
    .blank_attribute_i, .fails_o(fails), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input cmd_e c, input logic [7:0] ch, input logic [7:0] at,
                           input logic [POS_W-1:0] p);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= c;
    char_code_i <= ch;
    attribute_i <= at;
    position_i  <= p;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_blank(input logic [7:0] value);
    settle();
    blank_attribute_we_i <= 1'b1;
    blank_attribute_i    <= value;
    @(posedge clk_i);
    blank_attribute_we_i <= 1'b0;
  endtask

  task automatic send_random();
    int               r;
    int               sel;
    cmd_e             c;
    logic [7:0]       ch;
    logic [7:0]       at;
    logic [POS_W-1:0] p;
    r   = $urandom_range(99);
    sel = $urandom_range(9);
    ch  = 8'($urandom_range(255));
    at  = 8'($urandom_range(255));
    p   = POS_W'($urandom_range(CELL_TOTAL - 1));
    if ($urandom_range(7) == 0) ch = NEWLINE_CODE;
    if (r < 40) begin
      c = CMD_PUT_CURSOR;
    end else if (r < 60) begin
      c = CMD_PUT_POS;
      if (sel == 0) p = POS_W'($urandom_range((1 << POS_W) - 1, CELL_TOTAL));
      else if (sel < 3) p = POS_W'($urandom_range(CELL_TOTAL - 1, CELL_TOTAL - COLUMNS));
      if (p < CELL_TOTAL && ch != NEWLINE_CODE) last_put_pos = p;
    end else if (r < 85) begin
      c = CMD_READ;
      if (sel == 0) p = POS_W'($urandom_range((1 << POS_W) - 1, CELL_TOTAL));
      else if (sel < 5) p = last_put_pos;
    end else begin
      c = CMD_SET_CURSOR;
      if (sel == 0) p = POS_W'($urandom_range((1 << POS_W) - 1, CELL_TOTAL));
      else if (sel < 6) p = POS_W'($urandom_range(CELL_TOTAL - 1, CELL_TOTAL - COLUMNS));
    end
    send_item(c, ch, at, p);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset contents, byte extremes, out-of-range positions, scroll paths
    send_item(CMD_READ, 8'h00, 8'h00, POS_W'(0));
    send_item(CMD_READ, 8'hFF, 8'hFF, POS_W'(CELL_TOTAL - 1));
    send_item(CMD_PUT_CURSOR, 8'h00, 8'h00, '1);
    send_item(CMD_PUT_CURSOR, 8'hFF, 8'hFF, POS_W'(0));
    send_item(CMD_PUT_CURSOR, NEWLINE_CODE, 8'h5A, POS_W'(0));
    send_item(CMD_READ, 8'h00, 8'h00, POS_W'(1));
    send_item(CMD_PUT_POS, 8'hAA, 8'h55, POS_W'(CELL_TOTAL - 1));
    send_item(CMD_READ, 8'h00, 8'h00, POS_W'(CELL_TOTAL - 1));
    send_item(CMD_PUT_POS, 8'h01, 8'h80, '1);
    send_item(CMD_READ, 8'h00, 8'h00, '1);
    send_item(CMD_READ, 8'h00, 8'h00, POS_W'(CELL_TOTAL));
    send_item(CMD_SET_CURSOR, 8'h00, 8'h00, POS_W'(CELL_TOTAL));
    send_item(CMD_SET_CURSOR, 8'h00, 8'h00, POS_W'(CELL_TOTAL - 1));
    send_item(CMD_PUT_CURSOR, 8'h41, 8'h07, POS_W'(0));
    send_item(CMD_READ, 8'h00, 8'h00, POS_W'(CELL_TOTAL - COLUMNS - 1));
    send_item(CMD_READ, 8'h00, 8'h00, POS_W'(CELL_TOTAL - 1));
    send_item(CMD_PUT_POS, NEWLINE_CODE, 8'h00, POS_W'(CELL_TOTAL - 5));
    send_item(CMD_PUT_POS, NEWLINE_CODE, 8'hFF, POS_W'(0));
    send_item(CMD_PUT_POS, NEWLINE_CODE, 8'h00, POS_W'(CELL_TOTAL));
    send_item(CMD_SET_CURSOR, 8'h00, 8'h00, POS_W'(CELL_TOTAL - COLUMNS + 3));
    send_item(CMD_PUT_CURSOR, NEWLINE_CODE, 8'h00, POS_W'(0));
    send_item(CMD_SET_CURSOR, 8'h00, 8'h00, POS_W'(1023));
    send_item(CMD_PUT_CURSOR, NEWLINE_CODE, 8'h00, POS_W'(1024));
    send_item(CMD_SET_CURSOR, 8'h00, 8'h00, POS_W'(1024));
    send_item(CMD_READ, 8'h00, 8'h00, POS_W'(COLUMNS - 1));

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       write_blank(8'h00);
        1:       write_blank(8'hFF);
        default: write_blank(8'($urandom_range(255)));
      endcase
      idle_pct  = idle_tbl[ph];
      stall_pct = stall_tbl[ph];
      repeat (100) send_random();
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fails == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
